### rtl/core/csvs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// csvs_pkg
// Shared constants and types of the CSV row and column scanner.
// ============================================================================
package csvs_pkg;

    // character codes
    localparam logic [15:0] CH_NUL    = 16'h0000;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam logic [15:0] CH_SQUOTE = 16'h0027;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] CH_LF     = 16'h000A;

    // input op codes (s_tuser)
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result kinds (m_tuser)
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_ROW    = 1'b1;

    // qualifier modes
    localparam logic [1:0] QUAL_NONE   = 2'd0;
    localparam logic [1:0] QUAL_DQUOTE = 2'd1;
    localparam logic [1:0] QUAL_SQUOTE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SEPARATOR = 2'd0;
    localparam logic [1:0] CFG_QUALIFIER = 2'd1;
    localparam logic [1:0] CFG_FIRST_OFF = 2'd2;

    localparam logic [15:0] SEPARATOR_RST = 16'd44;
    localparam logic [1:0]  QUALIFIER_RST = QUAL_DQUOTE;
    localparam logic [1:0]  FIRST_OFF_RST = 2'd0;

    localparam int OFF_W = 40;

    // result tdata layout
    localparam int OUT_W       = 136;
    localparam int F_ROW_OFF   = 0;
    localparam int F_COL_NUM   = 40;
    localparam int F_COL_CHARS = 48;
    localparam int F_COL_WIDE  = 72;
    localparam int F_FIRST     = 96;
    localparam int F_KNOWN     = 97;
    localparam int F_LONGEST   = 106;
    localparam int F_OVERFLOW  = 130;
    localparam int F_PAD       = 131;

    typedef struct packed {
        logic kind;
        logic first_seen;
        logic overflow;
    } ev_flags_t;

endpackage

### rtl/core/csvs_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// csvs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module csvs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/csvs_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// csvs_queue
// Small register FIFO between the scanner front and the column table back.
// ============================================================================
module csvs_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/core/csvs_front.sv
`timescale 1ns / 1ps
// ============================================================================
// csvs_front
// Character classifier and row/column scanner; emits column and row close
// events with everything except the per-column table maximum.
// ============================================================================
module csvs_front #(
    parameter int MAX_COLUMNS = 256,
    parameter int LEN_BITS    = 24,
    parameter int IDX_W       = $clog2(MAX_COLUMNS + 1)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_addr,
    input  logic [15:0]               cfg_wdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,
    input  logic                      s_tuser,
    output logic                      ev_valid,
    input  logic                      ev_ready,
    output csvs_pkg::ev_flags_t       ev_flags,
    output logic [csvs_pkg::OFF_W-1:0] ev_row_off,
    output logic [IDX_W-1:0]          ev_idx,
    output logic [LEN_BITS-1:0]       ev_chars,
    output logic [LEN_BITS-1:0]       ev_longest,
    output logic [IDX_W-1:0]          ev_count
);

    typedef enum logic [2:0] {
        ST_NEWLINE    = 3'd0,
        ST_NEWLINE_CR = 3'd1,
        ST_NEWLINE_LF = 3'd2,
        ST_DATA       = 3'd3,
        ST_QUOTED     = 3'd4,
        ST_QUOTE_SEEN = 3'd5
    } state_t;

    localparam logic [IDX_W-1:0]    MAX_IDX = IDX_W'(MAX_COLUMNS);
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    logic [15:0]                sep_reg;
    logic [1:0]                 qual_reg;
    logic [1:0]                 first_off_reg;
    state_t                     state_reg, state_next;
    logic [csvs_pkg::OFF_W-1:0] row_start_reg, row_start_next;
    logic [LEN_BITS-1:0]        row_chars_reg, row_chars_next;
    logic [LEN_BITS-1:0]        row_max_reg, row_max_next;
    logic [LEN_BITS-1:0]        col_chars_reg, col_chars_next;
    logic [IDX_W-1:0]           col_index_reg, col_index_next;
    logic [IDX_W-1:0]           col_count_reg, col_count_next;
    logic                       seen_any_reg, seen_any_next;
    logic                       started_reg, started_next;

    logic [csvs_pkg::OFF_W-1:0] rs;
    logic [15:0]                c;
    logic                       accept, at_nl, is_term, is_paired, is_qual, emit, kind;
    state_t                     st2;

    assign s_tready = ev_ready;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;
    assign rs       = started_reg ? row_start_reg : csvs_pkg::OFF_W'(first_off_reg);
    assign at_nl    = (state_reg == ST_NEWLINE) || (state_reg == ST_NEWLINE_CR) ||
                      (state_reg == ST_NEWLINE_LF);
    assign is_term  = (c == csvs_pkg::CH_NUL) ||
                      (((c == csvs_pkg::CH_CR) || (c == csvs_pkg::CH_LF)) &&
                       (state_reg != ST_QUOTED));
    assign is_paired = ((state_reg == ST_NEWLINE_CR) && (c == csvs_pkg::CH_LF)) ||
                       ((state_reg == ST_NEWLINE_LF) && (c == csvs_pkg::CH_CR));
    assign is_qual  = ((qual_reg == csvs_pkg::QUAL_DQUOTE) && (c == csvs_pkg::CH_DQUOTE)) ||
                      ((qual_reg == csvs_pkg::QUAL_SQUOTE) && (c == csvs_pkg::CH_SQUOTE));

    always_comb begin
        state_next     = state_reg;
        row_start_next = row_start_reg;
        row_chars_next = row_chars_reg;
        row_max_next   = row_max_reg;
        col_chars_next = col_chars_reg;
        col_index_next = col_index_reg;
        col_count_next = col_count_reg;
        seen_any_next  = seen_any_reg;
        started_next   = started_reg;
        emit           = 1'b0;
        kind           = csvs_pkg::KIND_ROW;
        st2            = at_nl ? ST_DATA : state_reg;
        if (accept) begin
            started_next   = 1'b1;
            row_start_next = rs;
            if (s_tuser == csvs_pkg::OP_END) begin
                if (seen_any_reg && !at_nl) begin
                    emit           = 1'b1;
                    row_start_next = rs + csvs_pkg::OFF_W'(row_chars_reg);
                    row_chars_next = '0;
                    col_chars_next = '0;
                    col_index_next = '0;
                    state_next     = ST_NEWLINE;
                end
            end else begin
                seen_any_next = 1'b1;
                if (is_term) begin
                    if (is_paired) begin
                        row_start_next = rs + 1'b1;
                        state_next     = ST_NEWLINE;
                    end else begin
                        emit           = 1'b1;
                        row_start_next = rs + csvs_pkg::OFF_W'(row_chars_reg) + 1'b1;
                        row_chars_next = '0;
                        col_chars_next = '0;
                        col_index_next = '0;
                        if (c == csvs_pkg::CH_NUL) begin
                            state_next = ST_NEWLINE;
                        end else if (c == csvs_pkg::CH_CR) begin
                            state_next = ST_NEWLINE_CR;
                        end else begin
                            state_next = ST_NEWLINE_LF;
                        end
                    end
                end else begin
                    row_chars_next = (row_chars_reg == LEN_MAX) ? LEN_MAX
                                                                : row_chars_reg + 1'b1;
                    if (row_chars_next > row_max_reg) begin
                        row_max_next = row_chars_next;
                    end
                    state_next = st2;
                    if (is_qual) begin
                        if ((st2 == ST_DATA) && (col_chars_reg == '0)) begin
                            state_next = ST_QUOTED;
                        end else if (st2 == ST_QUOTED) begin
                            state_next = ST_QUOTE_SEEN;
                        end else begin
                            if (st2 == ST_QUOTE_SEEN) begin
                                state_next = ST_QUOTED;
                            end
                            col_chars_next = (col_chars_reg == LEN_MAX) ? LEN_MAX
                                                                        : col_chars_reg + 1'b1;
                        end
                    end else if ((st2 != ST_QUOTED) && (c == sep_reg)) begin
                        emit           = 1'b1;
                        kind           = csvs_pkg::KIND_COLUMN;
                        col_chars_next = '0;
                        state_next     = ST_DATA;
                        if (col_index_reg < MAX_IDX) begin
                            col_index_next = col_index_reg + 1'b1;
                        end
                    end else begin
                        col_chars_next = (col_chars_reg == LEN_MAX) ? LEN_MAX
                                                                    : col_chars_reg + 1'b1;
                    end
                end
            end
        end

        ev_flags.kind       = kind;
        ev_flags.overflow   = (col_index_reg >= MAX_IDX);
        ev_flags.first_seen = (col_index_reg < MAX_IDX) && (col_index_reg >= col_count_reg);
        ev_count            = col_count_reg + IDX_W'(ev_flags.first_seen);
        if (emit) begin
            col_count_next = ev_count;
        end
    end

    assign ev_valid   = emit;
    assign ev_row_off = rs;
    assign ev_idx     = col_index_reg;
    assign ev_chars   = col_chars_reg;
    assign ev_longest = row_max_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg       <= csvs_pkg::SEPARATOR_RST;
            qual_reg      <= csvs_pkg::QUALIFIER_RST;
            first_off_reg <= csvs_pkg::FIRST_OFF_RST;
            state_reg     <= ST_DATA;
            row_start_reg <= '0;
            row_chars_reg <= '0;
            row_max_reg   <= '0;
            col_chars_reg <= '0;
            col_index_reg <= '0;
            col_count_reg <= '0;
            seen_any_reg  <= 1'b0;
            started_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    csvs_pkg::CFG_SEPARATOR: sep_reg       <= cfg_wdata;
                    csvs_pkg::CFG_QUALIFIER: qual_reg      <= cfg_wdata[1:0];
                    csvs_pkg::CFG_FIRST_OFF: first_off_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            state_reg     <= state_next;
            row_start_reg <= row_start_next;
            row_chars_reg <= row_chars_next;
            row_max_reg   <= row_max_next;
            col_chars_reg <= col_chars_next;
            col_index_reg <= col_index_next;
            col_count_reg <= col_count_next;
            seen_any_reg  <= seen_any_next;
            started_reg   <= started_next;
        end
    end

endmodule

### rtl/core/csvs_back.sv
`timescale 1ns / 1ps
// ============================================================================
// csvs_back
// Column table read-modify-write and result register. One table read stage,
// then update/write with forwarding of the previous write, then output.
// ============================================================================
module csvs_back #(
    parameter int MAX_COLUMNS = 256,
    parameter int LEN_BITS    = 24,
    parameter int IDX_W       = $clog2(MAX_COLUMNS + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  csvs_pkg::ev_flags_t         q_flags,
    input  logic [csvs_pkg::OFF_W-1:0]  q_row_off,
    input  logic [IDX_W-1:0]            q_idx,
    input  logic [LEN_BITS-1:0]         q_chars,
    input  logic [LEN_BITS-1:0]         q_longest,
    input  logic [IDX_W-1:0]            q_count,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [csvs_pkg::OUT_W-1:0]  m_tdata,
    output logic                        m_tuser
);

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic                       b_vld_reg;
    csvs_pkg::ev_flags_t        b_flags_reg;
    logic [csvs_pkg::OFF_W-1:0] b_row_off_reg;
    logic [IDX_W-1:0]           b_idx_reg;
    logic [LEN_BITS-1:0]        b_chars_reg;
    logic [LEN_BITS-1:0]        b_longest_reg;
    logic [IDX_W-1:0]           b_count_reg;

    logic                       fwd_vld_reg;
    logic [ADDR_W-1:0]          fwd_addr_reg;
    logic [LEN_BITS-1:0]        fwd_data_reg;

    logic                       m_vld_reg;
    logic [csvs_pkg::OUT_W-1:0] m_data_reg;
    logic                       m_kind_reg;

    logic [LEN_BITS-1:0]        rd_data, old_max, widest;
    logic [ADDR_W-1:0]          b_addr;
    logic                       adv_b, load_b, wr_en;
    logic [csvs_pkg::OUT_W-1:0] out_word;

    assign adv_b   = b_vld_reg && (!m_vld_reg || m_tready);
    assign q_ready = !b_vld_reg || adv_b;
    assign load_b  = q_valid && q_ready;
    assign b_addr  = ADDR_W'(b_idx_reg);
    assign wr_en   = adv_b && !b_flags_reg.overflow;

    csvs_ram #(
        .WIDTH(LEN_BITS),
        .DEPTH(MAX_COLUMNS)
    ) u_table (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(b_addr),
        .wdata(widest),
        .re   (load_b),
        .raddr(ADDR_W'(q_idx)),
        .rdata(rd_data)
    );

    always_comb begin
        old_max = (fwd_vld_reg && (fwd_addr_reg == b_addr)) ? fwd_data_reg : rd_data;
        if (b_flags_reg.overflow) begin
            widest = '0;
        end else if (b_flags_reg.first_seen) begin
            widest = b_chars_reg;
        end else begin
            widest = (old_max > b_chars_reg) ? old_max : b_chars_reg;
        end
        out_word = '0;
        out_word[csvs_pkg::F_ROW_OFF +: 40]  = b_row_off_reg;
        out_word[csvs_pkg::F_COL_NUM +: 8]   = (32'(b_idx_reg) > 32'd255) ? 8'd255
                                                                           : 8'(b_idx_reg);
        out_word[csvs_pkg::F_COL_CHARS +: 24] = 24'(b_chars_reg);
        out_word[csvs_pkg::F_COL_WIDE +: 24]  = 24'(widest);
        out_word[csvs_pkg::F_FIRST]           = b_flags_reg.first_seen;
        out_word[csvs_pkg::F_KNOWN +: 9]      = 9'(b_count_reg);
        out_word[csvs_pkg::F_LONGEST +: 24]   = 24'(b_longest_reg);
        out_word[csvs_pkg::F_OVERFLOW]        = b_flags_reg.overflow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg   <= 1'b0;
            fwd_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            if (load_b) begin
                b_vld_reg <= 1'b1;
            end else if (adv_b) begin
                b_vld_reg <= 1'b0;
            end
            if (wr_en) begin
                fwd_vld_reg <= 1'b1;
            end
            if (adv_b) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_b) begin
            b_flags_reg   <= q_flags;
            b_row_off_reg <= q_row_off;
            b_idx_reg     <= q_idx;
            b_chars_reg   <= q_chars;
            b_longest_reg <= q_longest;
            b_count_reg   <= q_count;
        end
        if (wr_en) begin
            fwd_addr_reg <= b_addr;
            fwd_data_reg <= widest;
        end
        if (adv_b) begin
            m_data_reg <= out_word;
            m_kind_reg <= b_flags_reg.kind;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule

### rtl/core/csv_row_column_scanner_core.sv
`timescale 1ns / 1ps
// ============================================================================
// csv_row_column_scanner_core
// CSV scanner: splits a 16-bit character stream into columns and rows and
// keeps per-column maximum lengths and the longest row.
// ============================================================================
// One character transaction is taken every cycle while the result path keeps
// up; each column or row close gives one result transaction. The scanner front
// settles each character in its cycle of acceptance; closes pass through a
// four-entry queue to the back, where the column table lives in a RAM with a
// registered read: a close is read, then updated, written and loaded into the
// output register. Back-to-back closes of one column are served by forwarding
// the last write, so the back also sustains one result per cycle while the
// output is not stalled. The table needs no clearing pass after reset: an
// entry is always written before it is read.
module csv_row_column_scanner_core #(
    parameter int MAX_COLUMNS = 256,
    parameter int LEN_BITS    = 24
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [15:0]                cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // char_code
    input  logic                       s_tuser,   // op
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // row_offset, column_number, column_chars, column_widest,
    // column_first_seen, columns_known, longest_row, column_overflow, zero pad
    output logic [csvs_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tuser    // kind
);

    localparam int IDX_W = $clog2(MAX_COLUMNS + 1);
    localparam int EV_W  = $bits(csvs_pkg::ev_flags_t) + csvs_pkg::OFF_W +
                           2 * IDX_W + 2 * LEN_BITS;

    logic                       ev_valid, ev_ready;
    csvs_pkg::ev_flags_t        ev_flags, q_flags;
    logic [csvs_pkg::OFF_W-1:0] ev_row_off, q_row_off;
    logic [IDX_W-1:0]           ev_idx, q_idx, ev_count, q_count;
    logic [LEN_BITS-1:0]        ev_chars, q_chars, ev_longest, q_longest;
    logic                       q_valid, q_ready;
    logic [EV_W-1:0]            q_in, q_out;

    csvs_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .LEN_BITS   (LEN_BITS),
        .IDX_W      (IDX_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_flags  (ev_flags),
        .ev_row_off(ev_row_off),
        .ev_idx    (ev_idx),
        .ev_chars  (ev_chars),
        .ev_longest(ev_longest),
        .ev_count  (ev_count)
    );

    assign q_in = {ev_flags, ev_row_off, ev_idx, ev_chars, ev_longest, ev_count};

    csvs_queue #(
        .WIDTH(EV_W),
        .DEPTH(4)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (ev_valid),
        .in_ready (ev_ready),
        .in_data  (q_in),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_out)
    );

    assign {q_flags, q_row_off, q_idx, q_chars, q_longest, q_count} = q_out;

    csvs_back #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .LEN_BITS   (LEN_BITS),
        .IDX_W      (IDX_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_flags  (q_flags),
        .q_row_off(q_row_off),
        .q_idx    (q_idx),
        .q_chars  (q_chars),
        .q_longest(q_longest),
        .q_count  (q_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/core/csvs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// csvs_checker
// Port-level checks on the result channel of the CSV scanner.
// ============================================================================
module csvs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [csvs_pkg::OUT_W-1:0] m_tdata,
    input logic                       m_tuser
);

    // stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[csvs_pkg::F_OVERFLOW] |->
            !m_tdata[csvs_pkg::F_FIRST] && (m_tdata[csvs_pkg::F_COL_WIDE +: 24] == 24'd0))
        else $error("overflow column reports table data");

    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[csvs_pkg::F_FIRST] |->
            (m_tdata[csvs_pkg::F_COL_WIDE +: 24] == m_tdata[csvs_pkg::F_COL_CHARS +: 24]) &&
            (m_tdata[csvs_pkg::F_KNOWN +: 9] != 9'd0))
        else $error("first-seen column widest differs from its length");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[csvs_pkg::OUT_W-1:csvs_pkg::F_PAD] == '0))
        else $error("padding bits not zero");

endmodule

bind csv_row_column_scanner_core csvs_checker u_csvs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

### verif/tb_csv_row_column_scanner_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_csv_row_column_scanner_core
// Self-checking bench for the CSV scanner. A directed table covers the corner
// cases of quoting and row termination. Random CSV text follows under a range
// of separator and qualifier settings, with random stalls on both streams.
// Every column and row close is compared with a behavioral scan model or typed row.
// ============================================================================
module tb_csv_row_column_scanner_core;

    localparam int MAX_COLS     = 256;
    localparam int LEN_BITS     = 24;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 105;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
    localparam logic [1:0] QUAL_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        SC_NEWLINE    = 3'd0,
        SC_NEWLINE_CR = 3'd1,
        SC_NEWLINE_LF = 3'd2,
        SC_DATA       = 3'd3,
        SC_QUOTED     = 3'd4,
        SC_QUOTE_SEEN = 3'd5
    } scan_state_t;

    typedef struct packed {
        logic                      kind;
        logic [csvs_pkg::OFF_W-1:0] row_offset;
        logic [7:0]                column_number;
        logic [LEN_BITS-1:0]       column_chars;
        logic [LEN_BITS-1:0]       column_widest;
        logic                      first_seen;
        logic [8:0]                columns_known;
        logic [LEN_BITS-1:0]       longest_row;
        logic                      overflow;
    } close_rec_t;

    typedef struct packed {
        logic        op;
        logic [15:0] ch;
    } char_item_t;

    typedef struct packed {
        char_item_t item;
        logic       typed;
        logic       has;
        close_rec_t rec;
    } dir_row_t;

    typedef struct packed {
        logic [15:0] sep;
        logic [1:0]  qual;
        logic [1:0]  first_off;
        logic        wide;
    } setting_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [1:0]                 cfg_addr  = csvs_pkg::CFG_SEPARATOR;
    logic [15:0]                cfg_wdata = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [15:0]                s_tdata   = '0;
    logic                       s_tuser   = csvs_pkg::OP_CHAR;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [csvs_pkg::OUT_W-1:0] m_tdata;
    logic                       m_tuser;

    // scan model state
    logic [15:0]                p_sep       = csvs_pkg::SEPARATOR_RST;
    logic [1:0]                 p_qual      = csvs_pkg::QUALIFIER_RST;
    logic [1:0]                 p_first_off = csvs_pkg::FIRST_OFF_RST;
    scan_state_t                p_state     = SC_DATA;
    logic [csvs_pkg::OFF_W-1:0] p_row_start = '0;
    logic [LEN_BITS-1:0]        p_row_chars = '0;
    logic [LEN_BITS-1:0]        p_row_max   = '0;
    logic [LEN_BITS-1:0]        p_col_chars = '0;
    logic [8:0]                 p_col_index = '0;
    logic [8:0]                 p_col_count = '0;
    logic [LEN_BITS-1:0]        p_widest [0:MAX_COLS-1];
    logic                       p_seen      = 1'b0;
    logic                       p_started   = 1'b0;

    close_rec_t pending_closes [$];
    char_item_t stim_q [$];

    int err_count   = 0;
    int sent_count  = 0;
    int cycle_count = 0;
    int tx_idle_pct = 13;
    int rx_idle_pct = 62;
    int hold_req    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;

    dir_row_t dir_tab [0:22] = '{
        '{'{csvs_pkg::OP_END,  16'h0000}, 1'b1, 1'b0, '0},  // end before any text
        '{'{csvs_pkg::OP_CHAR, 16'h0061}, 1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_CHAR, 16'h002C}, 1'b1, 1'b1,
          '{csvs_pkg::KIND_COLUMN, 40'd3, 8'd0, 24'd1, 24'd1, 1'b1, 9'd1, 24'd2, 1'b0}},
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_DQUOTE}, 1'b0, 1'b0, '0}, // opens quoted column
        '{'{csvs_pkg::OP_CHAR, 16'h002C},  1'b0, 1'b0, '0}, // separator inside quotes
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_DQUOTE}, 1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_DQUOTE}, 1'b0, 1'b0, '0}, // doubled qualifier
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_CR},     1'b0, 1'b0, '0}, // CR inside quotes
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_DQUOTE}, 1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_CHAR, 16'h0078},  1'b0, 1'b0, '0}, // text after closing qualifier
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_CR},     1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_LF},     1'b0, 1'b0, '0}, // CR/LF pair
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_LF},     1'b0, 1'b0, '0}, // empty row
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_CR},     1'b0, 1'b0, '0}, // LF/CR pair
        '{'{csvs_pkg::OP_CHAR, 16'hFFFF},  1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_NUL},    1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_END,  16'hFFFF},  1'b1, 1'b0, '0}, // end right after terminator
        '{'{csvs_pkg::OP_CHAR, 16'h0062},  1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_END,  16'h0000},  1'b0, 1'b0, '0}, // flush
        '{'{csvs_pkg::OP_END,  16'h0000},  1'b1, 1'b0, '0}, // repeated end
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_SQUOTE}, 1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_CHAR, 16'h8000},  1'b0, 1'b0, '0},
        '{'{csvs_pkg::OP_CHAR, csvs_pkg::CH_LF},     1'b0, 1'b0, '0}
    };

    setting_t setting_tab [0:8] = '{
        '{16'h002C,            csvs_pkg::QUAL_DQUOTE, 2'd1, 1'b0},
        '{16'h0009,            csvs_pkg::QUAL_SQUOTE, 2'd2, 1'b0},
        '{csvs_pkg::CH_DQUOTE, csvs_pkg::QUAL_DQUOTE, 2'd0, 1'b0},  // separator equals qualifier
        '{16'hFFFF,            csvs_pkg::QUAL_NONE,   2'd3, 1'b0},
        '{16'h002C,            csvs_pkg::QUAL_DQUOTE, 2'd0, 1'b1},  // row wider than the table
        '{csvs_pkg::CH_NUL,    QUAL_RESERVED,         2'd1, 1'b0},
        '{csvs_pkg::CH_LF,     csvs_pkg::QUAL_DQUOTE, 2'd2, 1'b0},
        '{csvs_pkg::CH_SQUOTE, csvs_pkg::QUAL_SQUOTE, 2'd3, 1'b0},
        '{csvs_pkg::CH_CR,     csvs_pkg::QUAL_NONE,   2'd0, 1'b0}
    };

    csv_row_column_scanner_core #(
        .MAX_COLUMNS (MAX_COLS),
        .LEN_BITS    (LEN_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    function automatic string describe(input close_rec_t r);
        return $sformatf({"kind=%0d off=%0d col=%0d chars=%0d widest=%0d ",
                          "first=%0d known=%0d longest=%0d ovf=%0d"},
                         r.kind, r.row_offset, r.column_number, r.column_chars,
                         r.column_widest, r.first_seen, r.columns_known, r.longest_row,
                         r.overflow);
    endfunction

    function automatic logic [15:0] plain_char();
        logic [15:0] ch;
        ch = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h7E, 16'h20));
        if (ch == p_sep || ch == csvs_pkg::CH_NUL || ch == csvs_pkg::CH_CR ||
            ch == csvs_pkg::CH_LF || ch == csvs_pkg::CH_DQUOTE ||
            ch == csvs_pkg::CH_SQUOTE) begin
            ch = 16'h0061;
        end
        return ch;
    endfunction

    function automatic logic [15:0] noise_char();
        case ($urandom_range(7))
            0: return csvs_pkg::CH_NUL;
            1: return csvs_pkg::CH_CR;
            2: return csvs_pkg::CH_LF;
            3: return csvs_pkg::CH_DQUOTE;
            4: return csvs_pkg::CH_SQUOTE;
            5: return p_sep;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic void push_char(input logic [15:0] ch);
        stim_q.push_back('{csvs_pkg::OP_CHAR, ch});
    endfunction

    function automatic void push_end();
        stim_q.push_back('{csvs_pkg::OP_END, 16'($urandom_range(16'hFFFF))});
    endfunction

    task automatic close_column(input logic kind, output close_rec_t r);
        r = '0;
        r.kind          = kind;
        r.row_offset    = p_row_start;
        r.column_number = (p_col_index > 9'd255) ? 8'hFF : p_col_index[7:0];
        r.column_chars  = p_col_chars;
        if (p_col_index >= MAX_COLS) begin
            r.overflow = 1'b1;
        end else if (p_col_index >= p_col_count) begin
            p_widest[p_col_count[7:0]] = p_col_chars;
            p_col_count = p_col_count + 1'b1;
            r.first_seen    = 1'b1;
            r.column_widest = p_col_chars;
        end else begin
            if (p_widest[p_col_index[7:0]] < p_col_chars) begin
                p_widest[p_col_index[7:0]] = p_col_chars;
            end
            r.column_widest = p_widest[p_col_index[7:0]];
        end
        r.columns_known = p_col_count;
        r.longest_row   = p_row_max;
    endtask

    task automatic predict_close(input char_item_t it, output logic got, output close_rec_t r);
        logic is_term;
        logic is_qual;
        logic at_boundary;
        got = 1'b0;
        r = '0;
        if (!p_started) begin
            p_row_start = csvs_pkg::OFF_W'(p_first_off);
            p_started = 1'b1;
        end
        at_boundary = (p_state == SC_NEWLINE || p_state == SC_NEWLINE_CR ||
                       p_state == SC_NEWLINE_LF);
        if (it.op == csvs_pkg::OP_END) begin
            if (p_seen && !at_boundary) begin
                close_column(csvs_pkg::KIND_ROW, r);
                got = 1'b1;
                p_row_start = p_row_start + csvs_pkg::OFF_W'(p_row_chars);
                p_row_chars = '0;
                p_col_chars = '0;
                p_col_index = '0;
                p_state = SC_NEWLINE;
            end
        end else begin
            p_seen = 1'b1;
            is_term = (it.ch == csvs_pkg::CH_NUL) ||
                      ((it.ch == csvs_pkg::CH_CR || it.ch == csvs_pkg::CH_LF) &&
                       p_state != SC_QUOTED);
            if (is_term && ((p_state == SC_NEWLINE_CR && it.ch == csvs_pkg::CH_LF) ||
                            (p_state == SC_NEWLINE_LF && it.ch == csvs_pkg::CH_CR))) begin
                p_row_start = p_row_start + 1'b1;
                p_state = SC_NEWLINE;
            end else if (is_term) begin
                close_column(csvs_pkg::KIND_ROW, r);
                got = 1'b1;
                p_row_start = p_row_start + csvs_pkg::OFF_W'(p_row_chars) + 1'b1;
                p_row_chars = '0;
                p_col_chars = '0;
                p_col_index = '0;
                p_state = (it.ch == csvs_pkg::CH_NUL) ? SC_NEWLINE :
                          (it.ch == csvs_pkg::CH_CR)  ? SC_NEWLINE_CR : SC_NEWLINE_LF;
            end else begin
                if (at_boundary) begin
                    p_state = SC_DATA;
                end
                p_row_chars = sat_inc(p_row_chars);
                if (p_row_chars > p_row_max) begin
                    p_row_max = p_row_chars;
                end
                is_qual = (p_qual == csvs_pkg::QUAL_DQUOTE && it.ch == csvs_pkg::CH_DQUOTE) ||
                          (p_qual == csvs_pkg::QUAL_SQUOTE && it.ch == csvs_pkg::CH_SQUOTE);
                if (is_qual) begin
                    if (p_state == SC_DATA && p_col_chars == '0) begin
                        p_state = SC_QUOTED;
                    end else if (p_state == SC_QUOTED) begin
                        p_state = SC_QUOTE_SEEN;
                    end else if (p_state == SC_QUOTE_SEEN) begin
                        p_state = SC_QUOTED;
                        p_col_chars = sat_inc(p_col_chars);
                    end else begin
                        p_col_chars = sat_inc(p_col_chars);
                    end
                end else if (p_state != SC_QUOTED && it.ch == p_sep) begin
                    close_column(csvs_pkg::KIND_COLUMN, r);
                    got = 1'b1;
                    if (p_col_index < MAX_COLS) begin
                        p_col_index = p_col_index + 1'b1;
                    end
                    p_col_chars = '0;
                    p_state = SC_DATA;
                end else begin
                    p_col_chars = sat_inc(p_col_chars);
                end
            end
        end
    endtask

    // one CSV row, mostly well formed, with random content
    task automatic gen_row(input int ncols);
        logic [15:0] qch;
        int          len;
        int          pick;
        qch = (p_qual == csvs_pkg::QUAL_SQUOTE) ? csvs_pkg::CH_SQUOTE : csvs_pkg::CH_DQUOTE;
        for (int c = 0; c < ncols; c++) begin
            if (c != 0) begin
                push_char(p_sep);
            end
            pick = $urandom_range(99);
            len = $urandom_range(6);
            if (pick < 10) begin
                for (int k = 0; k <= len; k++) push_char(noise_char());
            end else if (pick < 40) begin
                push_char(qch);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(9))
                        0, 1: begin
                            push_char(qch);
                            push_char(qch);
                        end
                        2: push_char(p_sep);
                        3: push_char(($urandom_range(1) == 0) ? csvs_pkg::CH_CR
                                                               : csvs_pkg::CH_LF);
                        default: push_char(plain_char());
                    endcase
                end
                push_char(qch);
                if ($urandom_range(9) == 0) begin
                    push_char(plain_char());
                end
            end else begin
                for (int k = 0; k < len; k++) push_char(plain_char());
            end
        end
        case ($urandom_range(9))
            0, 1, 2: push_char(csvs_pkg::CH_CR);
            3, 4: push_char(csvs_pkg::CH_LF);
            5, 6: begin
                push_char(csvs_pkg::CH_CR);
                push_char(csvs_pkg::CH_LF);
            end
            7: begin
                push_char(csvs_pkg::CH_LF);
                push_char(csvs_pkg::CH_CR);
            end
            8: push_char(csvs_pkg::CH_NUL);
            default: begin
                push_end();
                if ($urandom_range(1) == 0) begin
                    push_end();
                end
            end
        endcase
    endtask

    task automatic send_item(input char_item_t it, input logic typed, input logic typed_has,
                             input close_rec_t typed_rec);
        logic       got;
        close_rec_t rec;
        tx_idle_pct = (sent_count < 420) ? 13 : (sent_count < 840) ? 62 : 0;
        rx_idle_pct = (sent_count < 420) ? 62 : (sent_count < 840) ? 13 : 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= it.ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        predict_close(it, got, rec);
        if (typed) begin
            got = typed_has;
            rec = typed_rec;
        end
        if (got) begin
            pending_closes.push_back(rec);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_closes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            csvs_pkg::CFG_SEPARATOR: p_sep = val;
            csvs_pkg::CFG_QUALIFIER: p_qual = val[1:0];
            csvs_pkg::CFG_FIRST_OFF: p_first_off = val[1:0];
            default: ;
        endcase
    endtask

    // receiver: random back-pressure plus requested long hold-offs
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        close_rec_t seen_rec;
        close_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen_rec.kind          = m_tuser;
            seen_rec.row_offset    = m_tdata[csvs_pkg::F_ROW_OFF +: csvs_pkg::OFF_W];
            seen_rec.column_number = m_tdata[csvs_pkg::F_COL_NUM +: 8];
            seen_rec.column_chars  = m_tdata[csvs_pkg::F_COL_CHARS +: LEN_BITS];
            seen_rec.column_widest = m_tdata[csvs_pkg::F_COL_WIDE +: LEN_BITS];
            seen_rec.first_seen    = m_tdata[csvs_pkg::F_FIRST];
            seen_rec.columns_known = m_tdata[csvs_pkg::F_KNOWN +: 9];
            seen_rec.longest_row   = m_tdata[csvs_pkg::F_LONGEST +: LEN_BITS];
            seen_rec.overflow      = m_tdata[csvs_pkg::F_OVERFLOW];
            if (pending_closes.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected transaction: %s", describe(seen_rec));
                end
            end else begin
                want = pending_closes.pop_front();
                if (seen_rec !== want) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: expected %s", describe(want));
                        $display("          actual   %s", describe(seen_rec));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // separator and qualifier keep their reset values for the directed part
        cfg_write(csvs_pkg::CFG_FIRST_OFF, 16'd3);
        cfg_we <= 1'b0;
        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].has, dir_tab[i].rec);
        end

        foreach (setting_tab[ph]) begin
            drain_results();
            cfg_write(csvs_pkg::CFG_SEPARATOR, setting_tab[ph].sep);
            cfg_write(csvs_pkg::CFG_QUALIFIER, 16'(setting_tab[ph].qual));
            cfg_write(csvs_pkg::CFG_FIRST_OFF, 16'(setting_tab[ph].first_off));
            cfg_we <= 1'b0;
            stim_q.delete();
            if (setting_tab[ph].wide) begin
                // fills the column table and runs past its end
                n = $urandom_range(258, 262);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(4) == 0) begin
                        push_char(plain_char());
                    end
                    push_char(p_sep);
                end
                push_char(csvs_pkg::CH_LF);
            end
            while (stim_q.size() < PHASE_ITEMS) gen_row($urandom_range(1, 8));
            if (ph == 1) begin
                hold_req++;
            end
            foreach (stim_q[i]) send_item(stim_q[i], 1'b0, 1'b0, '0);
        end

        drain_results();
        if (err_count == 0 && pending_closes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
